FILE: hw/rtl/spatial_vote_probability_macros.svh
// Assertion macros shared by the spatial vote probability RTL.
`ifndef SPATIAL_VOTE_PROBABILITY_MACROS_SVH
`define SPATIAL_VOTE_PROBABILITY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SVP_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/svp_pkg.sv
// Shared types, fixed-point constants and helpers for the spatial vote probability block.
package svp_pkg;

  localparam int X_W = 49;  // distance / exp argument, unsigned Q.40
  localparam int E_W = 31;  // value in [0,1], Q.30
  localparam int Z_W = 47;  // |z|, unsigned Q.38
  localparam int CFG_IDX_W = 2;

  localparam int EXP_TERMS = 8;
  localparam int DIV_STEPS = 31;
  localparam int POLY_STEPS = 5;

  localparam logic [30:0] ONE_Q30          = 31'h4000_0000;
  localparam logic [28:0] LOG2E_Q28        = 29'd387270501;
  localparam logic [29:0] LN2_Q30          = 30'd744261118;
  localparam logic [27:0] AS_P_Q30         = 28'd248723596;
  localparam logic [28:0] INV_SQRT_2PI_Q30 = 29'd428361012;
  localparam logic [27:0] Z_CLAMP          = 28'h800_0000;  // 8.0 in Q.24

  localparam logic signed [32:0] AS_B1 = 33'sd342933307;
  localparam logic signed [32:0] AS_B2 = -33'sd382857446;
  localparam logic signed [32:0] AS_B3 = 33'sd1912847369;
  localparam logic signed [32:0] AS_B4 = -33'sd1955558716;
  localparam logic signed [32:0] AS_B5 = 33'sd1428371292;

  // Constant added after each Horner product of the tail polynomial.
  localparam logic signed [32:0] POLY_ADD [POLY_STEPS] = '{AS_B4, AS_B3, AS_B2, AS_B1, 33'sd0};

  localparam logic [15:0] WEIGHT_RESET = 16'd4096;
  localparam logic [15:0] BETA_RESET   = 16'd2560;
  localparam logic        MODE_RESET   = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_DIM_0 = 2'd0,
    REG_WEIGHT_DIM_1 = 2'd1,
    REG_BETA_SCALE   = 2'd2,
    REG_LINK_MODE    = 2'd3
  } cfg_reg_t;

  // Signed Q.30 product, truncated toward zero.
  function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pr;
    logic [32:0] m;
    ma = a[32] ? 32'(-a) : a[31:0];
    mb = b[32] ? 32'(-b) : b[31:0];
    pr = 64'(ma) * 64'(mb);
    m  = pr[62:30];
    return (a[32] ^ b[32]) ? -$signed(m) : $signed(m);
  endfunction

endpackage

FILE: hw/rtl/svp_dist.sv
// Weighted squared distances from the ideal point to the yea and nay points.
module svp_dist import svp_pkg::*; #(
  parameter int DIMS = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [1:0][15:0]     ideal_i,
  input  logic [1:0][15:0]     yea_i,
  input  logic [1:0][15:0]     nay_i,
  input  logic [15:0]          weight_i [DIMS],
  output logic                 vld_o,
  output logic [X_W-1:0]       dy_o,
  output logic [X_W-1:0]       dn_o
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic [15:0] ma_r [DIMS];
  logic [15:0] mb_r [DIMS];
  logic [31:0] sqa_r [DIMS];
  logic [31:0] sqb_r [DIMS];
  logic [47:0] pa_r [DIMS];
  logic [47:0] pb_r [DIMS];
  logic [X_W-1:0] dy_r, dn_r;
  logic [X_W-1:0] dy_sum, dn_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  for (genvar k = 0; k < DIMS; k++) begin : g_dim
    logic signed [16:0] da, db;
    assign da = $signed({ideal_i[k][15], ideal_i[k]}) - $signed({yea_i[k][15], yea_i[k]});
    assign db = $signed({ideal_i[k][15], ideal_i[k]}) - $signed({nay_i[k][15], nay_i[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        ma_r[k]  <= da[16] ? 16'(-da) : da[15:0];
        mb_r[k]  <= db[16] ? 16'(-db) : db[15:0];
        sqa_r[k] <= 32'(ma_r[k]) * 32'(ma_r[k]);
        sqb_r[k] <= 32'(mb_r[k]) * 32'(mb_r[k]);
        pa_r[k]  <= 48'(sqa_r[k]) * 48'(weight_i[k]);
        pb_r[k]  <= 48'(sqb_r[k]) * 48'(weight_i[k]);
      end
    end
  end

  always_comb begin
    dy_sum = '0;
    dn_sum = '0;
    for (int k = 0; k < DIMS; k++) begin
      dy_sum = dy_sum + X_W'(pa_r[k]);
      dn_sum = dn_sum + X_W'(pb_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dy_r <= dy_sum;
      dn_r <= dn_sum;
    end
  end

  assign vld_o = v4_r;
  assign dy_o  = dy_r;
  assign dn_o  = dn_r;

endmodule

FILE: hw/rtl/svp_exp.sv
// Pipelined exp(-x): base-2 split, order-8 Horner series, final shift.
`include "spatial_vote_probability_macros.svh"
module svp_exp import svp_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [SB_W-1:0] sb_i,
  input  logic [X_W-1:0]  x_i,
  output logic            vld_o,
  output logic [SB_W-1:0] sb_o,
  output logic [E_W-1:0]  e_o
);

  // context word: {sb, zero, n[4:0], y[29:0]}
  localparam int CW = SB_W + 36;

  logic            v1_r, v2_r, vo_r;
  logic [SB_W-1:0] sb1_r, sb2_r, sbo_r;
  logic [32:0]     t1_r;
  logic            z1_r, z2_r;
  logic [4:0]      n2_r;
  logic [29:0]     y2_r;
  logic [E_W-1:0]  e_r;
  logic [60:0]     t_prod;
  logic [53:0]     y_prod;

  logic            vld_s [0:EXP_TERMS];
  logic [CW-1:0]   ctx_s [0:EXP_TERMS];
  logic [30:0]     p_s   [0:EXP_TERMS];

  assign t_prod = 61'(x_i[47:16]) * 61'(LOG2E_Q28);
  assign y_prod = 54'(t1_r[23:0]) * 54'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      vo_r <= vld_s[EXP_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r <= sb_i;
      t1_r  <= t_prod[60:28];
      z1_r  <= x_i[48];
      sb2_r <= sb1_r;
      z2_r  <= z1_r | (t1_r[32:24] >= 9'd31);
      n2_r  <= t1_r[28:24];
      y2_r  <= y_prod[53:24];
      sbo_r <= ctx_s[EXP_TERMS][CW-1:36];
      e_r   <= ctx_s[EXP_TERMS][35] ? '0 : (p_s[EXP_TERMS] >> ctx_s[EXP_TERMS][34:30]);
    end
  end

  assign vld_s[0] = v2_r;
  assign ctx_s[0] = {sb2_r, z2_r, n2_r, y2_r};
  assign p_s[0]   = ONE_Q30;

  // Each term: multiply, divide by k via reciprocal, correct and subtract.
  for (genvar s = 0; s < EXP_TERMS; s++) begin : g_term
    localparam int K = EXP_TERMS - s;
    logic          a_v_r, b_v_r, c_v_r;
    logic [CW-1:0] a_c_r, b_c_r, c_c_r;
    logic [29:0]   a_m_r, b_m_r, b_q_r;
    logic [30:0]   c_p_r;
    logic [60:0]   mp;
    logic [29:0]   qe;
    logic [29:0]   q_fix;

    assign mp = 61'(ctx_s[s][29:0]) * 61'(p_s[s]);

    if (K == 1) begin : g_unit
      assign qe    = a_m_r;
      assign q_fix = b_q_r;
    end else begin : g_recip
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
      logic [61:0] rp;
      logic [32:0] rem;
      assign rp    = 62'(a_m_r) * 62'(RECIP);
      assign qe    = rp[61:32];
      assign rem   = 33'(b_m_r) - 33'(b_q_r) * 33'(K);
      assign q_fix = (rem >= 33'(K)) ? b_q_r + 30'd1 : b_q_r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r <= 1'b0;
        b_v_r <= 1'b0;
        c_v_r <= 1'b0;
      end else if (en) begin
        a_v_r <= vld_s[s];
        b_v_r <= a_v_r;
        c_v_r <= b_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_c_r <= ctx_s[s];
        a_m_r <= mp[59:30];
        b_c_r <= a_c_r;
        b_m_r <= a_m_r;
        b_q_r <= qe;
        c_c_r <= b_c_r;
        c_p_r <= ONE_Q30 - {1'b0, q_fix};
      end
    end

    assign vld_s[s+1] = c_v_r;
    assign ctx_s[s+1] = c_c_r;
    assign p_s[s+1]   = c_p_r;
  end

  assign vld_o = vo_r;
  assign sb_o  = sbo_r;
  assign e_o   = e_r;

  `SVP_ASSERT_IMPL(a_exp_le_one, vo_r, e_r <= ONE_Q30, "exp result above one")

endmodule

FILE: hw/rtl/svp_div.sv
// Pipelined restoring divider: 2^60 / d, one quotient bit per stage.
`include "spatial_vote_probability_macros.svh"
module svp_div import svp_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [SB_W-1:0] sb_i,
  input  logic [31:0]     d_i,
  output logic            vld_o,
  output logic [SB_W-1:0] sb_o,
  output logic [E_W-1:0]  q_o
);

  logic            vld_s [0:DIV_STEPS];
  logic [SB_W-1:0] sb_s  [0:DIV_STEPS];
  logic [31:0]     d_s   [0:DIV_STEPS];
  logic [31:0]     rem_s [0:DIV_STEPS];
  logic [E_W-1:0]  q_s   [0:DIV_STEPS];

  // Dividend bits above the quotient range leave 2^29 as partial remainder.
  assign vld_s[0] = vld_i;
  assign sb_s[0]  = sb_i;
  assign d_s[0]   = d_i;
  assign rem_s[0] = 32'h2000_0000;
  assign q_s[0]   = '0;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_bit
    logic            v_r;
    logic [SB_W-1:0] sb_r;
    logic [31:0]     d_r, rem_r;
    logic [E_W-1:0]  q_r;
    logic [32:0]     r2;
    logic            ge;

    assign r2 = {rem_s[i], 1'b0};
    assign ge = r2 >= {1'b0, d_s[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r  <= sb_s[i];
        d_r   <= d_s[i];
        rem_r <= ge ? 32'(r2 - {1'b0, d_s[i]}) : r2[31:0];
        q_r   <= {q_s[i][E_W-2:0], ge};
      end
    end

    assign vld_s[i+1] = v_r;
    assign sb_s[i+1]  = sb_r;
    assign d_s[i+1]   = d_r;
    assign rem_s[i+1] = rem_r;
    assign q_s[i+1]   = q_r;
  end

  assign vld_o = vld_s[DIV_STEPS];
  assign sb_o  = sb_s[DIV_STEPS];
  assign q_o   = q_s[DIV_STEPS];

  `SVP_ASSERT_IMPL(a_quot_le_one, vld_s[DIV_STEPS], q_s[DIV_STEPS] <= ONE_Q30,
                   "quotient above one")

endmodule

FILE: hw/rtl/svp_link.sv
// Link stage: normal CDF (A-S 26.2.17) or logistic CDF of |z|.
module svp_link import svp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           mode,
  input  logic           vld_i,
  input  logic           neg_i,
  input  logic [Z_W-1:0] zmag_i,
  output logic           vld_o,
  output logic           neg_o,
  output logic [E_W-1:0] cdf_o
);

  localparam int PC_W = 1 + 30 + E_W;  // {neg, dens, t}

  logic           a_v_r, b_v_r, c_v_r, o_v_r;
  logic           a_neg_r, b_neg_r, c_neg_r, o_neg_r;
  logic [27:0]    a_zq_r;
  logic [X_W-1:0] a_xl_r, b_x_r;
  logic [31:0]    b_pz_r, c_den_r;
  logic [29:0]    c_dens_r;
  logic [E_W-1:0] o_cdf_r;

  logic [32:0]    zq_full;
  logic [27:0]    zq_c;
  logic [55:0]    pz_prod, sq_prod;
  logic           e_v;
  logic [32:0]    e_sb;
  logic [E_W-1:0] e_val;
  logic [59:0]    dens_prod;
  logic           d_v;
  logic [30:0]    d_sb;
  logic [E_W-1:0] d_t;

  logic                  pv_s   [0:POLY_STEPS];
  logic [PC_W-1:0]       pc_s   [0:POLY_STEPS];
  logic signed [32:0]    poly_s [0:POLY_STEPS];

  logic                  t_v_r;
  logic [PC_W-1:0]       t_c_r;
  logic signed [32:0]    tail_r;
  logic [E_W-1:0]        tail_cl;

  assign zq_full = zmag_i[46:14];
  assign zq_c    = (zq_full > 33'(Z_CLAMP)) ? Z_CLAMP : zq_full[27:0];
  assign pz_prod = 56'(AS_P_Q30) * 56'(a_zq_r);
  assign sq_prod = 56'(a_zq_r) * 56'(a_zq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= vld_i;
      b_v_r <= a_v_r;
      c_v_r <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg_r  <= neg_i;
      a_zq_r   <= zq_c;
      a_xl_r   <= {zmag_i, 2'b00};
      b_neg_r  <= a_neg_r;
      b_pz_r   <= pz_prod[55:24];
      b_x_r    <= mode ? a_xl_r : X_W'(sq_prod[55:9]);
      c_neg_r  <= e_sb[32];
      c_dens_r <= dens_prod[59:30];
      c_den_r  <= 32'(ONE_Q30) + (mode ? 32'(e_val) : e_sb[31:0]);
    end
  end

  svp_exp #(.SB_W(33)) u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (b_v_r),
    .sb_i  ({b_neg_r, b_pz_r}),
    .x_i   (b_x_r),
    .vld_o (e_v),
    .sb_o  (e_sb),
    .e_o   (e_val)
  );

  assign dens_prod = 60'(e_val) * 60'(INV_SQRT_2PI_Q30);

  svp_div #(.SB_W(31)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (c_v_r),
    .sb_i  ({c_neg_r, c_dens_r}),
    .d_i   (c_den_r),
    .vld_o (d_v),
    .sb_o  (d_sb),
    .q_o   (d_t)
  );

  assign pv_s[0]   = d_v;
  assign pc_s[0]   = {d_sb, d_t};
  assign poly_s[0] = AS_B5;

  // Horner steps: product by t, then add the next coefficient.
  for (genvar j = 0; j < POLY_STEPS; j++) begin : g_poly
    logic               m_v_r, a_v2_r;
    logic [PC_W-1:0]    m_c_r, a_c2_r;
    logic signed [32:0] m_pr_r, a_poly_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_v_r  <= 1'b0;
        a_v2_r <= 1'b0;
      end else if (en) begin
        m_v_r  <= pv_s[j];
        a_v2_r <= m_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_c_r    <= pc_s[j];
        m_pr_r   <= mul_q30($signed({2'b00, pc_s[j][E_W-1:0]}), poly_s[j]);
        a_c2_r   <= m_c_r;
        a_poly_r <= m_pr_r + POLY_ADD[j];
      end
    end

    assign pv_s[j+1]   = a_v2_r;
    assign pc_s[j+1]   = a_c2_r;
    assign poly_s[j+1] = a_poly_r;
  end

  // Tail = density * polynomial, clamped to [0,1].
  assign tail_cl = tail_r[32] ? '0 :
                   (tail_r > $signed({2'b00, ONE_Q30})) ? ONE_Q30 : tail_r[E_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      t_v_r <= pv_s[POLY_STEPS];
      o_v_r <= t_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_c_r   <= pc_s[POLY_STEPS];
      tail_r  <= mul_q30($signed({3'b000, pc_s[POLY_STEPS][PC_W-2:E_W]}),
                         poly_s[POLY_STEPS]);
      o_neg_r <= t_c_r[PC_W-1];
      o_cdf_r <= mode ? t_c_r[E_W-1:0] : ONE_Q30 - tail_cl;
    end
  end

  assign vld_o = o_v_r;
  assign neg_o = o_neg_r;
  assign cdf_o = o_cdf_r;

endmodule

FILE: hw/rtl/spatial_vote_probability.sv
// Top level of the spatial vote probability pipeline.
// Computes the yea probability F(beta*(exp(-dy) - exp(-dn))) for one voter and
// one roll call per item, where dy and dn are the salience-weighted squared
// distances from the ideal point to the yea and nay points and F is the
// standard normal CDF (link_mode 0) or the logistic CDF (link_mode 1). The
// block is a fully pipelined datapath with one global stall: a new item is
// accepted every clock cycle while the stall is not active. Most of the
// pipeline depth lies in the two exp units in series (27 stages each, three
// per series term), the 31-stage quotient divider of the CDF and the tail
// polynomial. The result register decouples the sides: while a result waits,
// empty slots in the pipeline keep filling, so in_tready only drops once the
// last stage holds a finished item as well. Configuration may only be
// written while the pipeline is empty; cfg_ready is always high.
`include "spatial_vote_probability_macros.svh"
module spatial_vote_probability import svp_pkg::*; #(
  parameter int DIMS = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // {nay_coord_1, nay_coord_0, yea_coord_1, yea_coord_0, ideal_coord_1,
  //  ideal_coord_0}, 16 bits each, ideal_coord_0 in [15:0]
  input  logic [95:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // yea_probability in [15:0]
  output logic [15:0]          out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // config registers
  logic [15:0] weight_r [DIMS];
  logic [15:0] beta_r;
  logic        mode_r;
  logic        cfg_fire;

  // pipeline control
  logic        en;
  logic        out_free;

  logic [1:0][15:0] ideal, yea, nay;

  logic           dist_v;
  logic [X_W-1:0] dy, dn;
  logic           ey_v;
  logic [E_W-1:0] ey, en_e;

  logic           m_v_r, z_v_r;
  logic           m_neg_r, z_neg_r;
  logic [E_W-1:0] mag_r;
  logic [Z_W-1:0] zmag_r;

  logic           l_v, l_neg;
  logic [E_W-1:0] l_cdf, cdf_cl, cdf_sgn;
  logic [E_W-1:0] rnd;

  logic           fin_vld_r;
  logic [15:0]    fin_data_r;
  logic           out_valid_r;
  logic [15:0]    out_data_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIMS; k++) begin
        weight_r[k] <= WEIGHT_RESET;
      end
      beta_r <= BETA_RESET;
      mode_r <= MODE_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WEIGHT_DIM_0: weight_r[0] <= cfg_data;
        // second weight exists only for two-dimensional builds
        REG_WEIGHT_DIM_1: if (DIMS > 1) weight_r[DIMS-1] <= cfg_data;
        REG_BETA_SCALE:   beta_r <= cfg_data;
        REG_LINK_MODE:    mode_r <= cfg_data[0];
      endcase
    end
  end

  // Global advance: the whole pipeline moves unless the last stage holds a
  // finished item that the result register cannot take.
  assign out_free  = !out_valid_r || out_tready;
  assign en        = out_free || !fin_vld_r;
  assign in_tready = en;

  assign ideal = in_tdata[31:0];
  assign yea   = in_tdata[63:32];
  assign nay   = in_tdata[95:64];

  svp_dist #(.DIMS(DIMS)) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (in_tvalid),
    .ideal_i  (ideal),
    .yea_i    (yea),
    .nay_i    (nay),
    .weight_i (weight_r),
    .vld_o    (dist_v),
    .dy_o     (dy),
    .dn_o     (dn)
  );

  // yea and nay exponentials run side by side; the yea unit's valid
  // stands for both
  svp_exp #(.SB_W(1)) u_exp_yea (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (dist_v),
    .sb_i  (1'b0),
    .x_i   (dy),
    .vld_o (ey_v),
    .sb_o  (),
    .e_o   (ey)
  );

  svp_exp #(.SB_W(1)) u_exp_nay (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (dist_v),
    .sb_i  (1'b0),
    .x_i   (dn),
    .vld_o (),
    .sb_o  (),
    .e_o   (en_e)
  );

  // Utility difference: sign kept apart, zero counts as positive.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      z_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= ey_v;
      z_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_neg_r <= ey < en_e;
      mag_r   <= (ey < en_e) ? en_e - ey : ey - en_e;
      z_neg_r <= m_neg_r;
      zmag_r  <= Z_W'(mag_r) * Z_W'(beta_r);  // |z| in Q.38
    end
  end

  svp_link u_link (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .mode   (mode_r),
    .vld_i  (z_v_r),
    .neg_i  (z_neg_r),
    .zmag_i (zmag_r),
    .vld_o  (l_v),
    .neg_o  (l_neg),
    .cdf_o  (l_cdf)
  );

  // Mirror for negative z, round half up to Q0.16, saturate.
  assign cdf_cl  = (l_cdf > ONE_Q30) ? ONE_Q30 : l_cdf;
  assign cdf_sgn = l_neg ? ONE_Q30 - cdf_cl : cdf_cl;
  assign rnd     = cdf_sgn + E_W'(14'h2000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= l_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_data_r <= rnd[30] ? 16'hFFFF : rnd[29:14];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= fin_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SVP_ASSERT_IMPL(a_ready_when_empty, !out_valid_r, in_tready,
                   "input stalled with empty result register")
  `SVP_ASSERT_NEXT(a_fin_hold, out_valid_r && !out_tready && fin_vld_r,
                   fin_vld_r && $stable(fin_data_r), "last stage lost item during stall")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the spatial vote probability pipeline.
`timescale 1ns / 1ps
module testbench;
  import svp_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // {nay_coord_1, nay_coord_0, yea_coord_1, yea_coord_0, ideal_coord_1,
  //  ideal_coord_0}, ideal_coord_0 in [15:0]
  logic [95:0]      in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // yea_probability in [15:0]
  logic [15:0]      out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WEIGHT_DIM_0;
  logic [15:0]      cfg_data = '0;

  spatial_vote_probability i_dut (.*);

  always #4 clk = ~clk;

  // Shadow copy of the configuration, updated on each register write.
  logic [15:0] wt0 = WEIGHT_RESET, wt1 = WEIGHT_RESET, beta = BETA_RESET;
  logic        logistic = MODE_RESET;

  logic [95:0] pair_q [$];     // voter / roll-call pairs waiting to be offered
  logic [15:0] prob_q [$];     // predicted yea probabilities, oldest first
  int          n_err = 0;
  int          n_acc = 0;
  int          n_res = 0;
  int          send_pct = 30;
  int          recv_pct = 79;
  bit          took;           // item accepted at the last rising edge
  bit          hold_go = 0, hold_done = 0;
  int          hold_left = 0;
  int          cycles = 0;

  localparam longint unsigned ONE30 = 64'd1 << 30;

  // exp(-x): x in Q.40, result Q.30; truncated Taylor series on the fraction
  function automatic longint unsigned exp_neg_q30(longint unsigned x);
    longint unsigned xq, t, n, f, y, p;
    xq = x >> 16;
    if (xq >= (64'd1 << 32)) return 0;
    t = (xq * 64'(LOG2E_Q28)) >> 28;
    n = t >> 24;
    if (n >= 31) return 0;
    f = t & 64'hFF_FFFF;
    y = (f * 64'(LN2_Q30)) >> 24;
    p = ONE30;
    for (int k = 8; k >= 1; k--) p = ONE30 - ((y * p) >> 30) / longint'(k);
    return p >> n;
  endfunction

  function automatic longint sprod_q30(longint a, longint b);
    longint unsigned ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Normal CDF of |z| (Q.38) by the rational tail approximation, Q.30
  function automatic longint unsigned normal_q30(longint unsigned zmag);
    longint unsigned zq, pz, t, e, dens;
    longint poly, tail;
    zq = zmag >> 14;
    if (zq > (64'd8 << 24)) zq = 64'd8 << 24;
    pz = (64'(AS_P_Q30) * zq) >> 24;
    t = (ONE30 << 30) / (ONE30 + pz);
    poly = AS_B5;
    poly = AS_B4 + sprod_q30(t, poly);
    poly = AS_B3 + sprod_q30(t, poly);
    poly = AS_B2 + sprod_q30(t, poly);
    poly = AS_B1 + sprod_q30(t, poly);
    poly = sprod_q30(t, poly);
    e = exp_neg_q30((zq * zq) >> 9);
    dens = (e * 64'(INV_SQRT_2PI_Q30)) >> 30;
    tail = sprod_q30(dens, poly);
    if (tail < 0) tail = 0;
    if (tail > longint'(ONE30)) tail = ONE30;
    return ONE30 - tail;
  endfunction

  function automatic logic [15:0] yea_prob(logic [95:0] pair);
    longint unsigned dy, dn, ey, en, mag, zmag, cdf, r;
    longint id, a, b;
    logic [15:0] w [2];
    bit neg;
    dy = 0;
    dn = 0;
    w[0] = wt0;
    w[1] = wt1;
    for (int k = 0; k < 2; k++) begin
      id = $signed(pair[16*k +: 16]);
      a = id - longint'($signed(pair[16*(2+k) +: 16]));
      b = id - longint'($signed(pair[16*(4+k) +: 16]));
      if (a < 0) a = -a;
      if (b < 0) b = -b;
      dy += a * a * w[k];
      dn += b * b * w[k];
    end
    ey = exp_neg_q30(dy);
    en = exp_neg_q30(dn);
    neg = ey < en;
    mag = neg ? en - ey : ey - en;
    zmag = mag * beta;
    if (logistic) cdf = (ONE30 << 30) / (ONE30 + exp_neg_q30(zmag << 2));
    else cdf = normal_q30(zmag);
    if (cdf > ONE30) cdf = ONE30;
    if (neg) cdf = ONE30 - cdf;
    r = (cdf + (64'd1 << 13)) >> 14;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  // Rising edge: record handshakes, predict on input, check on output.
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_WEIGHT_DIM_0: wt0 = cfg_data;
          REG_WEIGHT_DIM_1: wt1 = cfg_data;
          REG_BETA_SCALE:   beta = cfg_data;
          REG_LINK_MODE:    logistic = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        prob_q.push_back(yea_prob(in_tdata));
        took = 1;
        n_acc++;
      end
      if (out_tvalid && out_tready) begin
        n_res++;
        if (prob_q.size() == 0) begin
          $error("unexpected result yea_probability=%0d", out_tdata);
          n_err++;
        end else begin
          logic [15:0] want;
          want = prob_q.pop_front();
          if (want !== out_tdata) begin
            $error("yea_probability: expected %0d, actual %0d", want, out_tdata);
            n_err++;
          end
        end
      end
    end
  end

  // Falling edge: offer the next pair, with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || took)) begin
      if (pair_q.size() > 0 && $urandom_range(99) >= send_pct) begin
        in_tdata <= pair_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    took = 0;
  end

  // Receiver: random stalls plus one long hold-off to back the pipeline up
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= 600;
      hold_done <= 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (pair_q.size() > 0 || prob_q.size() > 0 || in_tvalid) @(posedge clk);
  endtask

  function automatic logic [95:0] pack6(logic [15:0] i0, i1, y0, y1, n0, n1);
    return {n1, n0, y1, y0, i1, i0};
  endfunction

  // Most pairs sit close together so the exponentials stay off zero
  function automatic logic [95:0] rand_pair();
    logic [15:0] c [6];
    int sp;
    for (int k = 0; k < 6; k++) c[k] = $urandom;
    if ($urandom_range(99) < 80) begin
      sp = 1 << $urandom_range(4, 14);
      for (int k = 2; k < 6; k++)
        c[k] = c[k % 2] + 16'($urandom_range(0, 2*sp) - sp);
    end
    return pack6(c[0], c[1], c[2], c[3], c[4], c[5]);
  endfunction

  logic [15:0] ph_w0 [8] = '{16'd4096, 16'd0, 16'd65535, 16'd65535,
                             16'd4096, 16'd0, 16'd0, 16'd1};
  logic [15:0] ph_w1 [8] = '{16'd4096, 16'd0, 16'd65535, 16'd0,
                             16'd4096, 16'd0, 16'd0, 16'd65535};
  logic [15:0] ph_bt [8] = '{16'd2560, 16'd65535, 16'd65535, 16'd256,
                             16'd0, 16'd0, 16'd0, 16'd40000};
  bit          ph_md [8] = '{0, 1, 0, 1, 0, 0, 1, 1};

  initial begin
    logic [15:0] mx, mn;
    mx = 16'h7FFF;
    mn = 16'h8000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      // phases 5 and 6 pick random settings
      if (ph == 5 || ph == 6) begin
        ph_w0[ph] = $urandom;
        ph_w1[ph] = $urandom_range(0, 8191);
        ph_bt[ph] = $urandom;
      end
      if (ph < 3) begin send_pct = 30; recv_pct = 79; end
      else if (ph < 6) begin send_pct = 79; recv_pct = 30; end
      else begin send_pct = 0; recv_pct = 0; end
      write_reg(REG_WEIGHT_DIM_0, ph_w0[ph]);
      write_reg(REG_WEIGHT_DIM_1, ph_w1[ph]);
      write_reg(REG_BETA_SCALE, ph_bt[ph]);
      write_reg(REG_LINK_MODE, 16'(ph_md[ph]));
      @(negedge clk);
      cfg_valid <= 1'b0;
      if (ph == 0 || ph == 1) begin
        // directed corners: coincident points, extreme spans, equal distances
        pair_q.push_back(pack6(0, 0, 0, 0, 0, 0));
        pair_q.push_back(pack6(0, 0, 0, 0, 16'd16384, 0));
        pair_q.push_back(pack6(0, 0, 16'd16384, 0, 0, 0));
        pair_q.push_back(pack6(mx, mx, mx, mx, mn, mn));
        pair_q.push_back(pack6(mn, mn, mn, mn, mx, mx));
        pair_q.push_back(pack6(mx, mn, mn, mx, mx, mn));
        pair_q.push_back(pack6(mx, mx, mn, mn, mn, mn));
        pair_q.push_back(pack6(16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFE, 16'hFFFE));
        pair_q.push_back(pack6(16'd100, 0, 16'd200, 0, 16'd4000, 0));
        pair_q.push_back(pack6(0, 16'd8192, 0, 16'd8000, 0, mn));
        pair_q.push_back(pack6(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 0, 0));
      end
      if (ph == 6) hold_go = 1;
      for (int i = 0; i < 240; i++) pair_q.push_back(rand_pair());
      drain();   // sender waits for every result before the next setting
    end
    repeat (200) @(posedge clk);
    if (prob_q.size() > 0) begin
      $error("%0d results never arrived", prob_q.size());
      n_err++;
    end
    $display("covered %0d pairs / %0d results over 8 weight, beta and link settings",
             n_acc, n_res);
    if (n_err == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
